// ===== hw/rtl/sscev_pkg.sv =====
// Shared constants and types for the sensor snapshot change event block.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package sscev_pkg;

    localparam int MAX_BYTES   = 16;
    localparam int POS_W       = $clog2(MAX_BYTES);
    localparam int COUNT_W     = 5;
    localparam int ADDR_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int BIT_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;

    // Input item codes.
    localparam logic MODE_DATA   = 1'b0;
    localparam logic MODE_FORGET = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT = 2'd1;

    localparam logic [ADDR_W-1:0]  BASE_ADDR_RESET  = 16'd1;
    localparam logic [COUNT_W-1:0] BYTE_COUNT_RESET = 5'd1;

    // One classified byte: address of its bit zero, the new bits, and the
    // mask of bits that must be reported.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] bits;
        logic [BYTE_W-1:0] mask;
    } sscev_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sscev_front.sv =====
// Front end: accepts input beats, compares them with the stored snapshot and
// pushes the changed-bit mask into the queue. Depends on sscev_pkg.
`default_nettype none

module sscev_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          mode,
    input  wire logic [7:0]                    snapshot_byte,
    input  wire logic [sscev_pkg::ADDR_W-1:0]  base_addr,
    input  wire logic [sscev_pkg::COUNT_W-1:0] byte_count,
    input  wire logic                          q_full,
    output logic                               q_push,
    output sscev_pkg::sscev_entry_t            q_entry
);
    import sscev_pkg::*;

    logic [BYTE_W-1:0]  stored_reg [MAX_BYTES];
    logic [BYTE_W-1:0]  stored_next [MAX_BYTES];
    logic               known_reg;
    logic               known_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;

    logic               accept;
    logic [BYTE_W-1:0]  diff;
    logic [COUNT_W-1:0] eff_count;
    logic [COUNT_W-1:0] pos_inc;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (byte_count == '0)
        begin
            eff_count = COUNT_W'(1);
        end
        else if (byte_count > COUNT_W'(MAX_BYTES))
        begin
            eff_count = COUNT_W'(MAX_BYTES);
        end
        else
        begin
            eff_count = byte_count;
        end
    end

    assign diff    = known_reg ? (stored_reg[pos_reg] ^ snapshot_byte) : {BYTE_W{1'b1}};
    assign pos_inc = COUNT_W'(pos_reg) + COUNT_W'(1);

    assign q_entry.addr = base_addr + {{(ADDR_W-POS_W-BIT_IDX_W){1'b0}}, pos_reg,
                                       {BIT_IDX_W{1'b0}}};
    assign q_entry.bits = snapshot_byte;
    assign q_entry.mask = diff;
    assign q_push       = accept && (mode == MODE_DATA) && (diff != '0);

    always_comb
    begin
        stored_next = stored_reg;
        known_next  = known_reg;
        pos_next    = pos_reg;
        if (accept)
        begin
            if (mode == MODE_FORGET)
            begin
                for (int i = 0; i < MAX_BYTES; i++)
                begin
                    stored_next[i] = '0;
                end
                known_next = 1'b0;
                pos_next   = '0;
            end
            else
            begin
                stored_next[pos_reg] = snapshot_byte;
                if (pos_inc >= eff_count)
                begin
                    pos_next   = '0;
                    known_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_inc[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BYTES; i++)
            begin
                stored_reg[i] <= '0;
            end
            known_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            stored_reg <= stored_next;
            known_reg  <= known_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sscev_queue.sv =====
// Short queue of classified bytes between the front end and the emitter.
// Depends on sscev_pkg for the entry type and depth.
`default_nettype none

module sscev_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire sscev_pkg::sscev_entry_t push_entry,
    input  wire logic                    pop,
    output sscev_pkg::sscev_entry_t      head,
    output logic                         not_empty,
    output logic                         full
);
    import sscev_pkg::*;

    sscev_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sscev_back.sv =====
// Event emitter: walks the changed-bit mask of one queued byte, lowest bit
// first, one event beat per cycle while out_stall is low. Depends on sscev_pkg.
`default_nettype none

module sscev_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sscev_pkg::sscev_entry_t      q_head,
    input  wire logic                         q_not_empty,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [sscev_pkg::ADDR_W-1:0]      sensor_address,
    output logic                              occupied,
    output logic                              last_event
);
    import sscev_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic [ADDR_W-1:0]     addr_reg;
    logic [ADDR_W-1:0]     addr_next;
    logic [BYTE_W-1:0]     bits_reg;
    logic [BYTE_W-1:0]     bits_next;
    logic [BYTE_W-1:0]     mask_reg;
    logic [BYTE_W-1:0]     mask_next;

    logic [BIT_IDX_W-1:0]  idx;
    logic [BYTE_W-1:0]     rest;
    logic                  fire;
    logic                  done;

    // Lowest set bit of the remaining mask.
    always_comb
    begin
        idx = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                idx = BIT_IDX_W'(i);
            end
        end
    end

    assign rest       = mask_reg & (mask_reg - 1'b1);
    assign last_event = (rest == '0);
    assign fire       = busy_reg && !out_stall;
    assign done       = !busy_reg || (fire && last_event);
    assign q_pop      = done && q_not_empty;

    assign out_valid      = busy_reg;
    assign sensor_address = addr_reg + {{(ADDR_W-BIT_IDX_W){1'b0}}, idx};
    assign occupied       = bits_reg[idx];

    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        bits_next = bits_reg;
        mask_next = mask_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
            addr_next = q_head.addr;
            bits_next = q_head.bits;
            mask_next = q_head.mask;
        end
        else if (fire)
        begin
            mask_next = rest;
            busy_next = !last_event;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mask_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        bits_reg <= bits_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sensor_snapshot_change_events_top.sv =====
// Top level of the sensor snapshot change event block: configuration
// registers and the front end, queue and emitter. Depends on sscev_pkg.
`default_nettype none

// Snapshot bytes are taken one beat per cycle while the two-entry queue has
// room; a forget beat or an unchanged byte produces no event. Each byte with n
// reported bits gives n events from the event emitter, so the sustained rate
// is set by the emitter at one event per cycle while out_stall is low; every
// bit of a byte is reported on the first snapshot.
// Output stall backs up into the queue and then into the input stall.
// Configuration writes are always taken (cfg_ready is high) and must only be
// issued while the block is idle.
module sensor_snapshot_change_events_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sscev_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                     cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            mode,
    input  wire logic [7:0]                      snapshot_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [15:0]                          sensor_address,
    output logic                                 occupied,
    output logic                                 last_event
);
    import sscev_pkg::*;

    logic [ADDR_W-1:0]  base_addr_reg;
    logic [ADDR_W-1:0]  base_addr_next;
    logic [COUNT_W-1:0] byte_count_reg;
    logic [COUNT_W-1:0] byte_count_next;

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_not_empty;
    sscev_entry_t       q_entry;
    sscev_entry_t       q_head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        base_addr_next  = base_addr_reg;
        byte_count_next = byte_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE_ADDR:  base_addr_next  = cfg_data;
                REG_BYTE_COUNT: byte_count_next = cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr_reg  <= BASE_ADDR_RESET;
            byte_count_reg <= BYTE_COUNT_RESET;
        end
        else
        begin
            base_addr_reg  <= base_addr_next;
            byte_count_reg <= byte_count_next;
        end
    end

    sscev_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .snapshot_byte (snapshot_byte),
        .base_addr     (base_addr_reg),
        .byte_count    (byte_count_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    sscev_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_not_empty),
        .full       (q_full)
    );

    sscev_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_head         (q_head),
        .q_not_empty    (q_not_empty),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sensor_address (sensor_address),
        .occupied       (occupied),
        .last_event     (last_event)
    );

endmodule

`default_nettype wire

// ===== tb/sensor_snapshot_change_events_top_tb.sv =====
// Self-checking testbench for sensor_snapshot_change_events_top: directed and random
// snapshot beats under random idling on both channels, checked against a local predictor.
// Depends on sscev_pkg and the RTL under hw/rtl.
`default_nettype none

module sensor_snapshot_change_events_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sscev_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        logic       mode;
        logic [7:0] data;
        int         gap;
    } snapshot_beat_t;

    typedef struct packed {
        logic [15:0] addr;
        logic        occ;
        logic        last;
    } sensor_event_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_BASE_ADDR;
    logic [15:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 mode = MODE_DATA;
    logic [7:0]           snapshot_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [15:0]          sensor_address;
    logic                 occupied;
    logic                 last_event;

    sensor_snapshot_change_events_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .snapshot_byte  (snapshot_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sensor_address (sensor_address),
        .occupied       (occupied),
        .last_event     (last_event)
    );

    // Stimulus and checking state.
    snapshot_beat_t snapshot_beats[$];
    sensor_event_t  due_events[$];
    bit             in_beat_taken = 1'b0;
    int             in_idle_max = 0;
    int             out_idle_max = 0;
    int             out_stall_left = 0;
    int             errors = 0;
    int             cycles = 0;

    // Predictor copy of the block state and registers.
    logic [7:0]  seen_bytes [MAX_BYTES];
    logic        snap_known = 1'b0;
    logic [3:0]  next_pos = '0;
    logic [15:0] base_addr = BASE_ADDR_RESET;
    logic [4:0]  count_reg = BYTE_COUNT_RESET;

    // Generator's rough view of the snapshot, used to make bytes that differ a little.
    logic [7:0] gen_prev [MAX_BYTES];
    int         gen_pos = 0;
    int         gen_count = 1;

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            seen_bytes[i] = '0;
            gen_prev[i] = '0;
        end
    end

    function automatic int clamp_count(input logic [4:0] c);
        if (c == 0)
            return 1;
        if (c > MAX_BYTES)
            return MAX_BYTES;
        return c;
    endfunction

    // Works out the events one accepted beat causes and updates the predicted state.
    task automatic predict_sensor_events(input logic m, input logic [7:0] b);
        logic [7:0]    changed;
        sensor_event_t ev;
        int            p;
        if (m == MODE_FORGET)
        begin
            for (int i = 0; i < MAX_BYTES; i++)
                seen_bytes[i] = '0;
            snap_known = 1'b0;
            next_pos = '0;
        end
        else
        begin
            p = next_pos;
            changed = snap_known ? (seen_bytes[p] ^ b) : 8'hff;
            seen_bytes[p] = b;
            for (int i = 0; i < 8; i++)
            begin
                if (changed[i])
                begin
                    ev.addr = base_addr + 16'(p * 8 + i);
                    ev.occ = b[i];
                    ev.last = ((changed >> (i + 1)) == 8'h00);
                    due_events.push_back(ev);
                end
            end
            p++;
            if (p >= clamp_count(count_reg))
            begin
                p = 0;
                snap_known = 1'b1;
            end
            next_pos = p[3:0];
        end
    endtask

    // Input driver: a beat stays on the bus until taken, then the next waits its gap.
    always @(negedge clk)
    begin
        bit             holding;
        snapshot_beat_t b;
        holding = in_valid && !in_beat_taken;
        in_beat_taken = 1'b0;
        if (rst_n && !holding)
        begin
            if (snapshot_beats.size() > 0 && snapshot_beats[0].gap == 0)
            begin
                b = snapshot_beats.pop_front();
                in_valid <= 1'b1;
                mode <= b.mode;
                snapshot_byte <= b.data;
            end
            else
            begin
                if (snapshot_beats.size() > 0)
                    snapshot_beats[0].gap--;
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_sensor_events(mode, snapshot_byte);
            in_beat_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (out_stall_left > 0)
        begin
            out_stall <= 1'b1;
            out_stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // Event monitor: every accepted event must match the oldest predicted one.
    always @(posedge clk)
    begin
        sensor_event_t ev;
        if (rst_n && out_valid && !out_stall)
        begin
            out_stall_left = $urandom_range(0, out_idle_max);
            if (due_events.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected event addr %h occupied %b last %b", $time,
                         sensor_address, occupied, last_event);
            end
            else
            begin
                ev = due_events.pop_front();
                if (sensor_address !== ev.addr)
                begin
                    errors++;
                    $display("%0t: sensor_address expected %h actual %h", $time,
                             ev.addr, sensor_address);
                end
                if (occupied !== ev.occ)
                begin
                    errors++;
                    $display("%0t: occupied expected %b actual %b", $time, ev.occ, occupied);
                end
                if (last_event !== ev.last)
                begin
                    errors++;
                    $display("%0t: last_event expected %b actual %b", $time,
                             ev.last, last_event);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_beat(input logic m, input logic [7:0] b);
        snapshot_beat_t beat;
        beat.mode = m;
        beat.data = b;
        beat.gap = $urandom_range(0, in_idle_max);
        snapshot_beats.push_back(beat);
        if (m == MODE_FORGET)
        begin
            for (int i = 0; i < MAX_BYTES; i++)
                gen_prev[i] = '0;
            gen_pos = 0;
        end
        else
        begin
            if (gen_pos >= gen_count)
                gen_pos = 0;
            gen_prev[gen_pos] = b;
            gen_pos = (gen_pos + 1 >= gen_count) ? 0 : gen_pos + 1;
        end
    endtask

    // Mostly well-formed snapshots whose bytes change by a few bits, with some
    // repeats, fresh bytes and forget beats that break a snapshot off.
    task automatic queue_random_beats(input int n, input int forget_pct);
        int         r;
        logic [7:0] b;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            b = gen_prev[gen_pos < gen_count ? gen_pos : 0];
            if (r < forget_pct)
                queue_beat(MODE_FORGET, 8'($urandom));
            else
            begin
                if (r < forget_pct + 55)
                begin
                    for (int j = $urandom_range(0, 3); j > 0; j--)
                        b[$urandom_range(0, 7)] ^= 1'b1;
                end
                else
                    b = 8'($urandom);
                queue_beat(MODE_DATA, b);
            end
        end
    endtask

    // Waits until every beat is taken and every event has come, then lets the
    // pipeline drain beats that produce no event.
    task automatic wait_idle();
        while (snapshot_beats.size() > 0 || in_valid || due_events.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_BASE_ADDR)
            base_addr = d;
        else if (idx == REG_BYTE_COUNT)
        begin
            count_reg = d[4:0];
            gen_count = clamp_count(d[4:0]);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int in_max, input int out_max);
        in_idle_max = in_max;
        out_idle_max = out_max;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: first snapshot reports every bit, then only changes.
        set_idling(6, 6);
        queue_beat(MODE_DATA, 8'h00);
        queue_beat(MODE_DATA, 8'h00);
        queue_beat(MODE_DATA, 8'hff);
        queue_beat(MODE_DATA, 8'hff);
        queue_beat(MODE_DATA, 8'h01);
        queue_beat(MODE_DATA, 8'h80);
        queue_beat(MODE_FORGET, 8'hff);
        queue_beat(MODE_DATA, 8'h55);
        queue_beat(MODE_DATA, 8'haa);
        queue_beat(MODE_DATA, 8'haa);
        wait_idle();

        // Addresses wrap past 0xffff; upper data bits of the count are dropped.
        write_register(REG_BASE_ADDR, 16'hfffc);
        write_register(REG_BYTE_COUNT, 16'hffe2);
        queue_beat(MODE_DATA, 8'h0f);
        queue_beat(MODE_DATA, 8'hf0);
        queue_beat(MODE_DATA, 8'hf0);
        queue_beat(MODE_DATA, 8'h0f);
        wait_idle();

        // A count of zero behaves as one.
        write_register(REG_BASE_ADDR, 16'h0000);
        write_register(REG_BYTE_COUNT, 16'h0000);
        queue_beat(MODE_DATA, 8'h81);
        queue_beat(MODE_DATA, 8'h7e);
        queue_beat(MODE_FORGET, 8'h00);
        queue_beat(MODE_DATA, 8'h00);
        wait_idle();

        // Shrink the count while a snapshot is half taken.
        write_register(REG_BASE_ADDR, 16'd100);
        write_register(REG_BYTE_COUNT, 16'd3);
        queue_beat(MODE_DATA, 8'h11);
        queue_beat(MODE_DATA, 8'h22);
        wait_idle();
        write_register(REG_BYTE_COUNT, 16'd2);
        queue_beat(MODE_DATA, 8'h33);
        queue_beat(MODE_DATA, 8'h44);
        wait_idle();

        // Counts above the maximum behave as the maximum.
        write_register(REG_BASE_ADDR, 16'hffff);
        write_register(REG_BYTE_COUNT, {11'($urandom), 5'd31});
        set_idling(18, 18);
        queue_random_beats(40, 5);
        wait_idle();

        write_register(REG_BASE_ADDR, 16'd1);
        write_register(REG_BYTE_COUNT, 16'd16);
        set_idling(0, 0);
        queue_random_beats(40, 4);
        wait_idle();

        write_register(REG_BASE_ADDR, 16'($urandom_range(1, 65535)));
        write_register(REG_BYTE_COUNT, 16'd5);
        set_idling(3, 18);
        queue_random_beats(30, 8);
        // Hold the sender off until every outstanding event has drained.
        while (snapshot_beats.size() > 0 || in_valid || due_events.size() > 0)
            @(posedge clk);
        set_idling(18, 0);
        queue_random_beats(30, 8);
        wait_idle();

        write_register(REG_BASE_ADDR, 16'($urandom_range(1, 65535)));
        write_register(REG_BYTE_COUNT, 16'd1);
        set_idling(5, 5);
        queue_random_beats(30, 10);
        wait_idle();

        write_register(REG_BASE_ADDR, 16'h8000);
        write_register(REG_BYTE_COUNT, 16'd8);
        set_idling(18, 18);
        queue_random_beats(40, 5);
        wait_idle();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
